>>> design/bbds_pkg.sv
// Package with the payload types, register indexes and constants of the duty splitter.
`timescale 1ns / 1ps

package bbds_pkg;

   localparam int unsigned DUTY_W    = 16;
   localparam int unsigned CURRENT_W = 12;
   localparam int unsigned DRIVE_W   = 12;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 16;

   // Drive value that separates the buck range from the boost range.
   localparam logic [DRIVE_W-1:0] DRIVE_MID   = 12'h800;
   localparam int unsigned        DRIVE_SHIFT = 5;

   localparam logic [CSR_IDX_W-1:0] REG_BUCK_DUTY_MAX     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BUCK_DUTY_MIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BOOST_DUTY_MAX    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BOOST_DUTY_MIN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BUCK_PERIOD       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BOOST_PERIOD      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CCM_ENTER_CURRENT = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_DCM_ENTER_CURRENT = 3'd7;

   typedef struct packed {
      logic [DUTY_W-1:0]    buck_duty_max;
      logic [DUTY_W-1:0]    buck_duty_min;
      logic [DUTY_W-1:0]    boost_duty_max;
      logic [DUTY_W-1:0]    boost_duty_min;
      logic [DUTY_W-1:0]    buck_period;
      logic [DUTY_W-1:0]    boost_period;
      logic [CURRENT_W-1:0] ccm_enter_current;
      logic [CURRENT_W-1:0] dcm_enter_current;
   } bbds_cfg_type;

   typedef struct packed {
      logic                 mode;
      logic [DUTY_W-1:0]    controller_result;
      logic [DRIVE_W-1:0]   drive_value;
      logic [CURRENT_W-1:0] output_current;
      logic                 converter_running;
   } bbds_req_type;

   typedef struct packed {
      logic [DUTY_W-1:0] buck_duty;
      logic [DUTY_W-2:0] buck_trigger;
      logic [DUTY_W-1:0] boost_duty;
      logic              continuous_mode;
   } bbds_rsp_type;

endpackage

>>> design/buck_boost_duty_splitter_core.sv
// Top level of the four-switch buck-boost duty splitter.
`timescale 1ns / 1ps

// Usage:
// Each beat on the req_ channel is one control period: mode, controller result,
// open-loop drive value, output current sample and the running flag. Each
// accepted beat yields exactly one beat on the rsp_ channel with the buck duty,
// buck ADC trigger, boost duty and the continuous-conduction flag.
// The csr_ channel writes the eight limit, period and threshold registers by
// index; it is always ready and should only be used while no beat is in flight.
// A beat accepted on the req_ channel waits in the input register while the
// clamp and multiply logic feeds the result register, which drives rsp_valid.
// Throughput is one beat per cycle while rsp_ready stays high; the single 16x16
// multiplier settles within that cycle.
// When the receiver stalls, the result register holds its beat and the input
// register takes one more; req_ready drops only when both are full and rsp_ready
// is low.
// Reset clears the configuration registers, both valid flags and the conduction
// flag, which starts in discontinuous mode.
module buck_boost_duty_splitter_core
   import bbds_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bbds_req_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bbds_rsp_type         rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   bbds_cfg_type cfg;
   bbds_req_type in_data_ff;
   bbds_rsp_type out_data_ff;
   bbds_rsp_type calc_rsp;
   logic         in_valid_ff;
   logic         out_valid_ff;
   logic         ccm_flag_ff;
   logic         ccm_flag_in;
   logic         advance;

   bbds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bbds_calc u_calc (
      .cfg       (cfg),
      .req       (in_data_ff),
      .flag_cur  (ccm_flag_ff),
      .flag_next (ccm_flag_in),
      .rsp       (calc_rsp)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || !out_valid_ff || rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ccm_flag_ff  <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            ccm_flag_ff  <= ccm_flag_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= calc_rsp;
      end
   end

`ifndef SYNTHESIS
   // The flag reported with a beat is the state the block keeps afterwards.
   a_flag_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_data_ff.continuous_mode == ccm_flag_ff))
      else $error("continuous_mode does not match the stored conduction flag");

   // The conduction flag only changes when a beat moves into the result register.
   a_flag_held_when_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(ccm_flag_ff))
      else $error("conduction flag changed without a beat");

   // With both registers empty the block must take a new beat.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      (!in_valid_ff && !out_valid_ff) |-> req_ready)
      else $error("req_ready low while the pipeline is empty");

   // A held input beat moves on as soon as the result register frees up.
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && rsp_ready && !req_valid) |=> out_valid_ff && !in_valid_ff)
      else $error("input beat not forwarded when the result register drained");
`endif

endmodule

>>> design/bbds_csr.sv
// Configuration register file of the duty splitter.
`timescale 1ns / 1ps

module bbds_csr
   import bbds_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   output bbds_cfg_type         cfg
);

   bbds_cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_BUCK_DUTY_MAX:     cfg_ff.buck_duty_max     <= csr_data;
            REG_BUCK_DUTY_MIN:     cfg_ff.buck_duty_min     <= csr_data;
            REG_BOOST_DUTY_MAX:    cfg_ff.boost_duty_max    <= csr_data;
            REG_BOOST_DUTY_MIN:    cfg_ff.boost_duty_min    <= csr_data;
            REG_BUCK_PERIOD:       cfg_ff.buck_period       <= csr_data;
            REG_BOOST_PERIOD:      cfg_ff.boost_period      <= csr_data;
            REG_CCM_ENTER_CURRENT: cfg_ff.ccm_enter_current <= csr_data[CURRENT_W-1:0];
            REG_DCM_ENTER_CURRENT: cfg_ff.dcm_enter_current <= csr_data[CURRENT_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

>>> design/bbds_calc.sv
// Duty computation and conduction-mode flag update for one control period.
`timescale 1ns / 1ps

module bbds_calc
   import bbds_pkg::*;
(
   input  bbds_cfg_type cfg,
   input  bbds_req_type req,
   input  logic         flag_cur,
   output logic         flag_next,
   output bbds_rsp_type rsp
);

   // The maximum is tested first, so a minimum above the maximum still lets
   // large values through as the maximum.
   function automatic logic [DUTY_W-1:0] clamp_duty(input logic [DUTY_W-1:0] v,
                                                    input logic [DUTY_W-1:0] lo,
                                                    input logic [DUTY_W-1:0] hi);
      logic [DUTY_W-1:0] r;
      if (v > hi) begin
         r = hi;
      end else if (v < lo) begin
         r = lo;
      end else begin
         r = v;
      end
      return r;
   endfunction

   logic [DUTY_W-1:0]   drive_shifted;
   logic [DUTY_W-1:0]   period_sel;
   logic [2*DUTY_W-1:0] product;
   logic [DUTY_W-1:0]   scaled;
   logic [DUTY_W-1:0]   excess;
   logic [DUTY_W-1:0]   buck_raw;
   logic [DUTY_W-1:0]   boost_raw;
   logic [DUTY_W-1:0]   buck_duty;
   logic                drive_high;
   logic                drive_low;
   logic                over_max;

   assign drive_high    = req.drive_value > DRIVE_MID;
   assign drive_low     = req.drive_value < DRIVE_MID;
   assign drive_shifted = DUTY_W'(DUTY_W'(req.drive_value) << DRIVE_SHIFT);

   // Only one leg uses the scaled drive at a time, so one multiplier serves both.
   assign period_sel = drive_high ? cfg.boost_period : cfg.buck_period;
   assign product    = drive_shifted * period_sel;
   assign scaled     = product[2*DUTY_W-1:DUTY_W];

   assign over_max = req.controller_result > cfg.buck_duty_max;
   assign excess   = req.controller_result - cfg.buck_duty_max;

   always_comb begin
      if (req.mode) begin
         buck_raw  = req.controller_result;
         boost_raw = over_max ? excess : cfg.boost_duty_min;
      end else begin
         buck_raw  = drive_low ? scaled : cfg.buck_duty_max;
         boost_raw = drive_high ? scaled : cfg.boost_duty_min;
      end
   end

   assign buck_duty = clamp_duty(buck_raw, cfg.buck_duty_min, cfg.buck_duty_max);

   // Hysteresis: the clear threshold wins when both thresholds are crossed.
   always_comb begin
      flag_next = flag_cur;
      if (req.mode && req.converter_running) begin
         if (req.output_current > cfg.ccm_enter_current) begin
            flag_next = 1'b1;
         end
         if (req.output_current < cfg.dcm_enter_current) begin
            flag_next = 1'b0;
         end
      end
   end

   assign rsp.buck_duty       = buck_duty;
   assign rsp.buck_trigger    = buck_duty[DUTY_W-1:1];
   assign rsp.boost_duty      = clamp_duty(boost_raw, cfg.boost_duty_min, cfg.boost_duty_max);
   assign rsp.continuous_mode = flag_next;

endmodule
